>>> rtl/core/drfa_pkg.sv
// Package: item types, parse phases and codes shared by the DNS response parser.
`timescale 1ns / 1ps
package drfa_pkg;

	localparam int HEADER_BYTES = 12;
	localparam int FIXED_BYTES  = 10;
	localparam int QFIXED_BYTES = 4;
	localparam logic [15:0] TYPE_A   = 16'd1;
	localparam logic [7:0]  PTR_MASK = 8'hC0;

	typedef enum logic [2:0] {
		ST_FOUND      = 3'd0,
		ST_NO_ANSWERS = 3'd1,
		ST_SHORT      = 3'd2,
		ST_MALFORMED  = 3'd3,
		ST_NO_A       = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_HEADER     = 4'd0,
		PH_Q_NAME     = 4'd1,
		PH_Q_FIXED    = 4'd2,
		PH_A_NAME     = 4'd3,
		PH_A_PTR      = 4'd4,
		PH_A_FIXED    = 4'd5,
		PH_A_DATA     = 4'd6,
		PH_DONE       = 4'd7,
		PH_NO_ANSWERS = 4'd8
	} phase_t;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] time_to_live;
		logic [15:0] record_data_length;
		logic [31:0] ipv4_address;
		logic        address_valid;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} res_push_t;

endpackage

>>> rtl/core/dns_response_first_a_record_unit.sv
// Top level: DNS response parser reporting the first A record of each message.
//
//  channel | direction | payload    | handshake
//  msg     | in        | in_item_t  | msg_valid / msg_stall
//  res     | out       | out_item_t | res_valid / res_stall
//
// One message byte is taken every cycle while msg_stall is low; the parse state updates in the same cycle.
// The result of a message is built from its final byte and registered in the output buffer.
// A two-entry output buffer lets bytes keep flowing while one result is stalled;
// msg_stall rises only when both entries are held.
// arst_n returns the parser to the header phase and empties the buffer.
`timescale 1ns / 1ps
module dns_response_first_a_record_unit #(
	parameter int MAX_MESSAGE_BYTES = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_stall,
	input  drfa_pkg::in_item_t  msg_item,
	output logic                res_valid,
	input  logic                res_stall,
	output drfa_pkg::out_item_t res_item
);
	import drfa_pkg::*;

	res_push_t push;
	logic      accept;

	assign accept = msg_valid && !msg_stall;

	drfa_parser #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (msg_item),
		.push  (push)
	);

	drfa_result_buffer u_buffer (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (msg_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

endmodule

>>> rtl/core/drfa_parser.sv
// Byte-wise parser state and the result built on the final byte of a message.
`timescale 1ns / 1ps
module drfa_parser #(
	parameter int MAX_MESSAGE_BYTES = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  drfa_pkg::in_item_t  item,
	output drfa_pkg::res_push_t push
);
	import drfa_pkg::*;

	localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

	logic [POS_W-1:0] pos_q, st_pos;
	phase_t           phase_q, st_phase;
	logic [15:0]      qleft_q, st_qleft;
	logic [15:0]      aleft_q, st_aleft;
	logic [15:0]      fbl_q, st_fbl;
	logic [15:0]      type_q, st_type;
	logic [31:0]      ttl_q, st_ttl;
	logic [15:0]      len_q, st_len;
	logic [31:0]      addr_q, st_addr;
	logic             found_q, st_found;

	logic [7:0]  b;
	logic [3:0]  k;
	logic [15:0] didx;
	logic [15:0] aleft_dec;
	status_t     status;

	assign b         = item.message_byte;
	assign k         = 4'(FIXED_BYTES) - fbl_q[3:0];
	assign didx      = len_q - fbl_q;
	assign aleft_dec = aleft_q - 16'd1;

	// Next state after taking one byte.
	always_comb begin
		st_pos   = pos_q;
		st_phase = phase_q;
		st_qleft = qleft_q;
		st_aleft = aleft_q;
		st_fbl   = fbl_q;
		st_type  = type_q;
		st_ttl   = ttl_q;
		st_len   = len_q;
		st_addr  = addr_q;
		st_found = found_q;
		if (32'(pos_q) < 32'(MAX_MESSAGE_BYTES)) begin
			st_pos = pos_q + POS_W'(1);
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q == POS_W'(4)) st_qleft = {b, 8'h00};
					if (pos_q == POS_W'(5)) st_qleft = {qleft_q[15:8], b};
					if (pos_q == POS_W'(6)) st_aleft = {b, 8'h00};
					if (pos_q == POS_W'(7)) st_aleft = {aleft_q[15:8], b};
					if (pos_q == POS_W'(HEADER_BYTES - 1)) begin
						st_fbl = '0;
						if (aleft_q == '0) st_phase = PH_NO_ANSWERS;
						else if (qleft_q != '0) st_phase = PH_Q_NAME;
						else st_phase = PH_A_NAME;
					end
				end
				PH_Q_NAME: begin
					if (fbl_q != '0) st_fbl = fbl_q - 16'd1;
					else if (b == 8'h00) begin
						st_phase = PH_Q_FIXED;
						st_fbl   = 16'(QFIXED_BYTES);
					end else st_fbl = {8'h00, b};
				end
				PH_Q_FIXED: begin
					st_fbl = fbl_q - 16'd1;
					if (fbl_q == 16'd1) begin
						st_qleft = qleft_q - 16'd1;
						st_phase = (qleft_q != 16'd1) ? PH_Q_NAME : PH_A_NAME;
					end
				end
				PH_A_NAME: begin
					if (fbl_q != '0) st_fbl = fbl_q - 16'd1;
					else if ((b & PTR_MASK) == PTR_MASK) st_phase = PH_A_PTR;
					else if (b == 8'h00) begin
						st_phase = PH_A_FIXED;
						st_fbl   = 16'(FIXED_BYTES);
					end else st_fbl = {8'h00, b};
				end
				PH_A_PTR: begin
					st_phase = PH_A_FIXED;
					st_fbl   = 16'(FIXED_BYTES);
				end
				PH_A_FIXED: begin
					if (k == 4'd0) st_type = {b, 8'h00};
					else if (k == 4'd1) st_type = {type_q[15:8], b};
					else if (k == 4'd4) st_ttl = {24'h0, b};
					else if (k >= 4'd5 && k <= 4'd7) st_ttl = {ttl_q[23:0], b};
					else if (k == 4'd8) st_len = {b, 8'h00};
					else if (k == 4'd9) st_len = {len_q[15:8], b};
					st_fbl = fbl_q - 16'd1;
					if (fbl_q == 16'd1) begin
						st_addr = '0;
						if (st_len != '0) begin
							st_phase = PH_A_DATA;
							st_fbl   = st_len;
						end else if (type_q == TYPE_A) begin
							st_found = 1'b1;
							st_phase = PH_DONE;
						end else begin
							st_aleft = aleft_dec;
							st_phase = (aleft_dec != '0) ? PH_A_NAME : PH_DONE;
						end
					end
				end
				PH_A_DATA: begin
					if (didx < 16'd4) st_addr = {addr_q[23:0], b};
					st_fbl = fbl_q - 16'd1;
					if (fbl_q == 16'd1) begin
						if (type_q == TYPE_A) begin
							st_found = 1'b1;
							st_phase = PH_DONE;
						end else begin
							st_aleft = aleft_dec;
							st_phase = (aleft_dec != '0) ? PH_A_NAME : PH_DONE;
						end
					end
				end
				PH_DONE, PH_NO_ANSWERS: begin
				end
			endcase
		end
	end

	// Result for the final byte of a message.
	always_comb begin
		priority if (st_phase == PH_HEADER) status = ST_SHORT;
		else if (st_phase == PH_NO_ANSWERS) status = ST_NO_ANSWERS;
		else if (st_found) status = ST_FOUND;
		else if (st_phase != PH_DONE) status = ST_MALFORMED;
		else status = ST_NO_A;

		push.valid       = accept && item.end_of_message;
		push.item.status = status;
		if (status == ST_FOUND) begin
			push.item.time_to_live       = st_ttl;
			push.item.record_data_length = st_len;
			push.item.ipv4_address       = st_addr;
			push.item.address_valid      = (st_len == 16'd4);
		end else begin
			push.item.time_to_live       = '0;
			push.item.record_data_length = '0;
			push.item.ipv4_address       = '0;
			push.item.address_valid      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_HEADER;
			qleft_q <= '0;
			aleft_q <= '0;
			fbl_q   <= '0;
			type_q  <= '0;
			ttl_q   <= '0;
			len_q   <= '0;
			addr_q  <= '0;
			found_q <= 1'b0;
		end else if (accept) begin
			if (item.end_of_message) begin
				// restart for the next message
				pos_q   <= '0;
				phase_q <= PH_HEADER;
				qleft_q <= '0;
				aleft_q <= '0;
				fbl_q   <= '0;
				type_q  <= '0;
				ttl_q   <= '0;
				len_q   <= '0;
				addr_q  <= '0;
				found_q <= 1'b0;
			end else begin
				pos_q   <= st_pos;
				phase_q <= st_phase;
				qleft_q <= st_qleft;
				aleft_q <= st_aleft;
				fbl_q   <= st_fbl;
				type_q  <= st_type;
				ttl_q   <= st_ttl;
				len_q   <= st_len;
				addr_q  <= st_addr;
				found_q <= st_found;
			end
		end
	end

endmodule

>>> rtl/core/drfa_result_buffer.sv
// Two-entry result register with skid stage between parser and result channel.
`timescale 1ns / 1ps
module drfa_result_buffer (
	input  logic                clk,
	input  logic                arst_n,
	input  drfa_pkg::res_push_t push,
	output logic                full,
	output logic                res_valid,
	input  logic                res_stall,
	output drfa_pkg::out_item_t res_item
);
	import drfa_pkg::*;

	logic      main_v_q, skid_v_q;
	out_item_t main_q, skid_q;

	assign full      = skid_v_q;
	assign res_valid = main_v_q;
	assign res_item  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || !res_stall) begin
			// advance: skid first, then a fresh item
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push.valid;
			end
		end else if (push.valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || !res_stall) begin
			if (skid_v_q) main_q <= skid_q;
			else if (push.valid) main_q <= push.item;
		end else if (push.valid) begin
			skid_q <= push.item;
		end
	end

endmodule
